// File: hdl/sass_pkg.sv
// ----------------------------------------------------------------------------
// Switch-avoiding sum sampler package
// Shared widths, reset values and the accumulator status type.
// ----------------------------------------------------------------------------
package sass_pkg;

  localparam int SAMPLE_W        = 12;               // sample port width
  localparam int BLEN_W          = 16;               // burst length / counts
  localparam int SUM_W           = 29;               // sum accumulators
  localparam int PROD_W          = SUM_W + BLEN_W;   // clean sum times length
  localparam int VAL_W           = 28;               // burst value result
  localparam int SAMPLE_BITS_DEF = 12;               // default sample resolution

  localparam logic [BLEN_W-1:0] BLEN_RST = BLEN_W'(16);

  // Accumulator status seen by the sequencer
  typedef struct packed {
    logic              last;       // next sample closes the running burst
    logic [BLEN_W-1:0] clean_cnt;  // clean samples so far
    logic [SUM_W-1:0]  clean_sum;  // sum of clean samples
    logic [SUM_W-1:0]  total_sum;  // sum of all samples
  } acc_t;

endpackage

// File: hdl/sass_accum.sv
// ----------------------------------------------------------------------------
// Burst accumulator
// Holds the total and clean sums, the clean count and the sample countdown.
// ----------------------------------------------------------------------------
module sass_accum
  import sass_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                take_i,
  input  logic                action_i,
  input  logic [SAMPLE_W-1:0] sample_i,
  input  logic                switch_near_i,
  input  logic [BLEN_W-1:0]   blen_i,
  output acc_t                stat_o
);

  localparam int SmpKeep = (SAMPLE_BITS < SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W;
  localparam logic [SAMPLE_W-1:0] SmpMask = SAMPLE_W'((64'd1 << SmpKeep) - 64'd1);

  logic [SUM_W-1:0]  total_q, total_d;
  logic [SUM_W-1:0]  clean_q, clean_d;
  logic [BLEN_W-1:0] remain_q, remain_d;
  logic [BLEN_W-1:0] ccnt_q, ccnt_d;
  logic [SUM_W-1:0]  smp_ext;

  assign smp_ext = {{(SUM_W - SAMPLE_W){1'b0}}, sample_i & SmpMask};

  always_comb begin
    total_d  = total_q;
    clean_d  = clean_q;
    remain_d = remain_q;
    ccnt_d   = ccnt_q;
    if (take_i) begin
      if (!action_i) begin
        // restart: clear sums, load the countdown
        total_d  = '0;
        clean_d  = '0;
        ccnt_d   = '0;
        remain_d = blen_i;
      end else if (remain_q != '0) begin
        total_d  = total_q + smp_ext;
        remain_d = remain_q - BLEN_W'(1);
        if (!switch_near_i) begin
          clean_d = clean_q + smp_ext;
          ccnt_d  = ccnt_q + BLEN_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q  <= '0;
      clean_q  <= '0;
      remain_q <= '0;
      ccnt_q   <= '0;
    end else begin
      total_q  <= total_d;
      clean_q  <= clean_d;
      remain_q <= remain_d;
      ccnt_q   <= ccnt_d;
    end
  end

  assign stat_o.last      = (remain_q == BLEN_W'(1));
  assign stat_o.clean_cnt = ccnt_q;
  assign stat_o.clean_sum = clean_q;
  assign stat_o.total_sum = total_q;

endmodule

// File: hdl/sass_mul.sv
// ----------------------------------------------------------------------------
// Serial multiplier
// Shift-add, one multiplier bit per cycle, LSB first.
// ----------------------------------------------------------------------------
module sass_mul
  import sass_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [SUM_W-1:0]  mcand_i,
  input  logic [BLEN_W-1:0] mplier_i,
  output logic              done_o,
  output logic [PROD_W-1:0] prod_o
);

  localparam int CntW = $clog2(BLEN_W);

  logic              busy_q;
  logic              done_q;
  logic [CntW-1:0]   cnt_q;
  logic [SUM_W-1:0]  mcand_q;
  logic [PROD_W-1:0] prod_q;
  logic [SUM_W:0]    psum;

  // add the multiplicand into the upper part when the current bit is set
  assign psum = {1'b0, prod_q[PROD_W-1:BLEN_W]} + (prod_q[0] ? {1'b0, mcand_q} : '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(BLEN_W - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CntW'(1);
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      mcand_q <= mcand_i;
      prod_q  <= {{SUM_W{1'b0}}, mplier_i};
    end else if (busy_q) begin
      prod_q <= {psum, prod_q[BLEN_W-1:1]};
    end
  end

  assign done_o = done_q;
  assign prod_o = prod_q;

endmodule

// File: hdl/sass_div.sv
// ----------------------------------------------------------------------------
// Serial divider
// Restoring division, one quotient bit per cycle, MSB first.
// ----------------------------------------------------------------------------
module sass_div
  import sass_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [PROD_W-1:0] dvd_i,
  input  logic [BLEN_W-1:0] dvs_i,
  output logic              done_o,
  output logic [VAL_W-1:0]  quo_o
);

  localparam int CntW = $clog2(PROD_W);

  logic              busy_q;
  logic              done_q;
  logic [CntW-1:0]   cnt_q;
  logic [PROD_W-1:0] dvd_q;
  logic [BLEN_W-1:0] dvs_q;
  logic [BLEN_W-1:0] rem_q;
  logic [VAL_W-1:0]  quo_q;
  logic [BLEN_W:0]   trial;
  logic [BLEN_W:0]   diff;
  logic              ge;

  assign trial = {rem_q, dvd_q[PROD_W-1]};
  assign diff  = trial - {1'b0, dvs_q};
  assign ge    = (trial >= {1'b0, dvs_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(PROD_W - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CntW'(1);
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // upper quotient bits only appear on wrapped sums and drop off the top
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dvd_i;
      dvs_q <= dvs_i;
      rem_q <= '0;
      quo_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[PROD_W-2:0], 1'b0};
      rem_q <= ge ? diff[BLEN_W-1:0] : trial[BLEN_W-1:0];
      quo_q <= {quo_q[VAL_W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

// File: hdl/switch_avoiding_sum_sampler_core.sv
// ----------------------------------------------------------------------------
// Switch-avoiding sum sampler
// Sums a burst of ADC samples, keeping samples taken near a bridge switch
// out of the clean sum, and rescales the clean sum to the full burst.
//
//   channel  direction  handshake            payload
//   in       input      in_valid_i/in_stall_o  action_i, sample_i, switch_near_i
//   out      output     out_valid_o/out_stall_i burst_value_o, clean_count_o,
//                                                fallback_o
//   cfg      input      cfg_we_i             cfg_wdata_i (burst length)
//
// A start or a sample that does not close a burst is taken without a stall.
// The sample that closes a burst stalls the input through the setup state,
// the serial multiplier (16 shift-add steps and a done pulse), the serial
// divider (45 steps and a done pulse) and the load of the output register.
// A burst with no clean sample skips both units and stalls the input only
// through the setup and load states. A stalled output extends the load state.
// Reset clears all sums and leaves no burst active; burst length resets to 16.
// A stalled result sits in the output register while new items transfer;
// a second result waits in the sequencer until that register frees up.
// ----------------------------------------------------------------------------
module switch_avoiding_sum_sampler_core
  import sass_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration
  input  logic                cfg_we_i,
  input  logic [BLEN_W-1:0]   cfg_wdata_i,
  // input channel
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                action_i,
  input  logic [SAMPLE_W-1:0] sample_i,
  input  logic                switch_near_i,
  // output channel
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [VAL_W-1:0]    burst_value_o,
  output logic [BLEN_W-1:0]   clean_count_o,
  output logic                fallback_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_MUL,
    ST_DIV,
    ST_PUBLISH
  } state_e;

  state_e            state_q;
  logic [BLEN_W-1:0] blen_q;

  logic              take;
  acc_t              acc;

  logic              mul_start;
  logic              mul_done;
  logic [PROD_W-1:0] prod;
  logic              div_start;
  logic              div_done;
  logic [VAL_W-1:0]  quo;

  // pending result, held until the output register is free
  logic [VAL_W-1:0]  res_val_q;
  logic              res_fb_q;

  logic              out_valid_q;
  logic [VAL_W-1:0]  out_val_q;
  logic [BLEN_W-1:0] out_ccnt_q;
  logic              out_fb_q;

  // accept items only in the idle state, while no burst result is being computed or published
  assign in_stall_o = (state_q != ST_IDLE);
  assign take       = in_valid_i && !in_stall_o;

  // burst length register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blen_q <= BLEN_RST;
    end else if (cfg_we_i) begin
      blen_q <= cfg_wdata_i;
    end
  end

  sass_accum #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_accum (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .take_i        (take),
    .action_i      (action_i),
    .sample_i      (sample_i),
    .switch_near_i (switch_near_i),
    .blen_i        (blen_q),
    .stat_o        (acc)
  );

  // rescale only when at least one clean sample exists
  assign mul_start = (state_q == ST_SETUP) && (acc.clean_cnt != '0);
  assign div_start = (state_q == ST_MUL) && mul_done;

  sass_mul u_mul (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (mul_start),
    .mcand_i  (acc.clean_sum),
    .mplier_i (blen_q),
    .done_o   (mul_done),
    .prod_o   (prod)
  );

  sass_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .dvd_i   (prod),
    .dvs_i   (acc.clean_cnt),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  // sequencer and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      res_val_q   <= '0;
      res_fb_q    <= 1'b0;
      out_valid_q <= 1'b0;
      out_val_q   <= '0;
      out_ccnt_q  <= '0;
      out_fb_q    <= 1'b0;
    end else begin
      // drop the result once the consumer takes it, unless a new one loads
      if (out_valid_q && !out_stall_i && (state_q != ST_PUBLISH)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          // the closing sample updates the sums at this same edge
          if (take && action_i && acc.last) begin
            state_q <= ST_SETUP;
          end
        end
        ST_SETUP: begin
          if (acc.clean_cnt == '0) begin
            // no clean sample: hand out the total sum
            res_val_q <= acc.total_sum[VAL_W-1:0];
            res_fb_q  <= 1'b1;
            state_q   <= ST_PUBLISH;
          end else begin
            state_q <= ST_MUL;
          end
        end
        ST_MUL: begin
          if (mul_done) begin
            state_q <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            res_val_q <= quo;
            res_fb_q  <= 1'b0;
            state_q   <= ST_PUBLISH;
          end
        end
        ST_PUBLISH: begin
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q <= 1'b1;
            out_val_q   <= res_val_q;
            out_ccnt_q  <= acc.clean_cnt;
            out_fb_q    <= res_fb_q;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o   = out_valid_q;
  assign burst_value_o = out_val_q;
  assign clean_count_o = out_ccnt_q;
  assign fallback_o    = out_fb_q;

endmodule
